// ===== sv/gray_to_tinted_rgba_macros.svh =====
`ifndef GRAY_TO_TINTED_RGBA_MACROS_SVH
`define GRAY_TO_TINTED_RGBA_MACROS_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define GTR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gray_to_tinted_rgba check failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define GTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gray_to_tinted_rgba check failed");

`endif

// ===== sv/gtr_pkg.sv =====
package gtr_pkg;

  localparam int ROOT_W = 12;
  localparam int REM_W = 14;

  localparam logic [1:0] CUT_NONE = 2'd0;
  localparam logic [1:0] CUT_LOW = 2'd1;
  localparam logic [1:0] CUT_HIGH = 2'd2;

  localparam logic [1:0] MODE_CONST = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_ROOT = 2'd2;

  localparam logic [2:0] REG_LOW_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_HIGH_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_TINT_COLOR = 3'd2;
  localparam logic [2:0] REG_ALPHA_MODE = 3'd3;
  localparam logic [2:0] REG_INVERT_ALPHA = 3'd4;
  localparam logic [2:0] REG_CONSTANT_ALPHA = 3'd5;
  localparam logic [2:0] REG_LINEAR_COEF = 3'd6;
  localparam logic [2:0] REG_ROOT_COEF = 3'd7;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // One restoring square-root digit: brings down two radicand bits.
  function automatic sqrt_t sqrt_step(sqrt_t cur, logic [1:0] pair);
    logic [REM_W+1:0] acc;
    logic [REM_W+1:0] trial;
    sqrt_t nxt;
    acc = {cur.rem, pair};
    trial = {2'b00, cur.root, 2'b01};
    if (acc >= trial) begin
      nxt.rem = REM_W'(acc - trial);
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem = acc[REM_W-1:0];
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  // Exact floor(p / 255) for any p below 65280.
  function automatic logic [7:0] div255(logic [15:0] p);
    logic [16:0] sum;
    sum = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
    return sum[15:8];
  endfunction

endpackage

// ===== sv/gtr_sqrt_stage.sv =====
module gtr_sqrt_stage (
  input  logic                          clk,
  input  logic                          en,
  input  logic [7:0]                    rad_in,
  input  logic [gtr_pkg::REM_W-1:0]     rem_in,
  input  logic [gtr_pkg::ROOT_W-1:0]    root_in,
  output logic [gtr_pkg::REM_W-1:0]     rem_out,
  output logic [gtr_pkg::ROOT_W-1:0]    root_out
);

  gtr_pkg::sqrt_t st [0:4];

  always_comb begin
    st[0].rem = rem_in;
    st[0].root = root_in;
    for (int k = 0; k < 4; k++) begin
      st[k+1] = gtr_pkg::sqrt_step(st[k], rad_in[7-2*k -: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= st[4].rem;
      root_out <= st[4].root;
    end
  end

endmodule

// ===== sv/gray_to_tinted_rgba.sv =====
// Five register stages lie between an input beat and its output beat.
// Throughput is one pixel per cycle unless the output stalls; each stage stalls only when the stage
// after it is full and stalled, so bubbles are squeezed out.
// The square root runs as three stages of four digits each.
// Synchronous active-high reset empties the pipeline and loads register defaults.
module gray_to_tinted_rgba (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // gray_in[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
  output logic [1:0]  m_axis_tuser,   // cut_reason[1:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [8:0]         low_threshold;
  logic [7:0]         high_threshold;
  logic [23:0]        tint_color;
  logic [1:0]         alpha_mode;
  logic               invert_alpha;
  logic [15:0]        constant_alpha;
  logic signed [15:0] linear_coef;
  logic signed [15:0] root_coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold <= 9'd0;
      high_threshold <= 8'd255;
      tint_color <= 24'hFFFFFF;
      alpha_mode <= gtr_pkg::MODE_CONST;
      invert_alpha <= 1'b0;
      constant_alpha <= 16'd255;
      linear_coef <= 16'sd256;
      root_coef <= 16'sd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gtr_pkg::REG_LOW_THRESHOLD: low_threshold <= cfg_data[8:0];
        gtr_pkg::REG_HIGH_THRESHOLD: high_threshold <= cfg_data[7:0];
        gtr_pkg::REG_TINT_COLOR: tint_color <= cfg_data;
        gtr_pkg::REG_ALPHA_MODE: alpha_mode <= cfg_data[1:0];
        gtr_pkg::REG_INVERT_ALPHA: invert_alpha <= cfg_data[0];
        gtr_pkg::REG_CONSTANT_ALPHA: constant_alpha <= cfg_data[15:0];
        gtr_pkg::REG_LINEAR_COEF: linear_coef <= cfg_data[15:0];
        gtr_pkg::REG_ROOT_COEF: root_coef <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || m_axis_tready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= s_axis_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Stage 1: cuts, alpha source, tint products, first square-root digits.
  logic [7:0]  gray;
  logic [7:0]  ga_next;
  logic [1:0]  reason_next;
  logic [1:0]  reason1, reason2, reason3, reason4;
  logic [7:0]  ga1;
  logic [15:0] pr1, pg1, pb1;

  assign gray = s_axis_tdata;
  assign ga_next = invert_alpha ? 8'd255 - gray : gray;

  always_comb begin
    if ({1'b0, gray} < low_threshold) begin
      reason_next = gtr_pkg::CUT_LOW;
    end else if (gray > high_threshold) begin
      reason_next = gtr_pkg::CUT_HIGH;
    end else begin
      reason_next = gtr_pkg::CUT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      reason1 <= reason_next;
      ga1 <= ga_next;
      pr1 <= {8'd0, gray} * {8'd0, tint_color[23:16]};
      pg1 <= {8'd0, gray} * {8'd0, tint_color[15:8]};
      pb1 <= {8'd0, gray} * {8'd0, tint_color[7:0]};
    end
  end

  logic [gtr_pkg::REM_W-1:0]  rem1, rem2, rem3;
  logic [gtr_pkg::ROOT_W-1:0] root1, root2, root3;

  gtr_sqrt_stage u_sqrt1 (
    .clk(clk), .en(en1), .rad_in(ga_next),
    .rem_in('0), .root_in('0), .rem_out(rem1), .root_out(root1)
  );

  // Stage 2: divide by 255, linear product, more root digits.
  logic [7:0]         r2, g2, b2, r3, g3, b3, r4, g4, b4;
  logic signed [24:0] lin2, lin3, lin4;

  always_ff @(posedge clk) begin
    if (en2) begin
      reason2 <= reason1;
      r2 <= gtr_pkg::div255(pr1);
      g2 <= gtr_pkg::div255(pg1);
      b2 <= gtr_pkg::div255(pb1);
      lin2 <= 25'($signed({1'b0, ga1})) * 25'(linear_coef);
    end
  end

  gtr_sqrt_stage u_sqrt2 (
    .clk(clk), .en(en2), .rad_in(8'd0),
    .rem_in(rem1), .root_in(root1), .rem_out(rem2), .root_out(root2)
  );

  // Stage 3: last root digits.
  always_ff @(posedge clk) begin
    if (en3) begin
      reason3 <= reason2;
      r3 <= r2;
      g3 <= g2;
      b3 <= b2;
      lin3 <= lin2;
    end
  end

  gtr_sqrt_stage u_sqrt3 (
    .clk(clk), .en(en3), .rad_in(8'd0),
    .rem_in(rem2), .root_in(root2), .rem_out(rem3), .root_out(root3)
  );

  // Stage 4: root gain product.
  logic signed [28:0] rt4;

  always_ff @(posedge clk) begin
    if (en4) begin
      reason4 <= reason3;
      r4 <= r3;
      g4 <= g3;
      b4 <= b3;
      lin4 <= lin3;
      rt4 <= 29'($signed({1'b0, root3})) * 29'(root_coef);
    end
  end

  // Stage 5: alpha clamp and selection into the output register, which zeroes cut pixels.
  logic [7:0] lin_alpha, root_alpha, const_alpha, alpha;

  always_comb begin
    if (lin4[24]) begin
      lin_alpha = 8'd0;
    end else if (lin4[23:16] != 8'd0) begin
      lin_alpha = 8'd255;
    end else begin
      lin_alpha = lin4[15:8];
    end
    if (rt4[28]) begin
      root_alpha = 8'd0;
    end else if (rt4[27:24] != 4'd0) begin
      root_alpha = 8'd255;
    end else begin
      root_alpha = rt4[23:16];
    end
    const_alpha = (constant_alpha[15:8] != 8'd0) ? 8'd255 : constant_alpha[7:0];
    unique case (alpha_mode)
      gtr_pkg::MODE_LINEAR: alpha = lin_alpha;
      gtr_pkg::MODE_ROOT: alpha = root_alpha;
      default: alpha = const_alpha;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      m_axis_tuser <= reason4;
      if (reason4 == gtr_pkg::CUT_NONE) begin
        m_axis_tdata <= {alpha, b4, g4, r4};
      end else begin
        m_axis_tdata <= 32'd0;
      end
    end
  end

  assign m_axis_tvalid = v5;

endmodule

// ===== sv/gtr_checker.sv =====
`include "gray_to_tinted_rgba_macros.svh"

module gtr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic stalled;
  assign stalled = m_axis_tvalid && !m_axis_tready;

  `GTR_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid)
  `GTR_ASSERT_NEXT(a_out_stable, stalled, $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `GTR_ASSERT_SAME(a_cut_black, m_axis_tvalid && m_axis_tuser != gtr_pkg::CUT_NONE, m_axis_tdata == 32'd0)
  `GTR_ASSERT_SAME(a_reason_code, m_axis_tvalid, m_axis_tuser != 2'd3)
  `GTR_ASSERT_SAME(a_empty_out_ready, !m_axis_tvalid, s_axis_tready)

endmodule

bind gray_to_tinted_rgba gtr_checker u_gtr_checker (.*);

// ===== bench/tb_gray_to_tinted_rgba.sv =====
module tb_gray_to_tinted_rgba;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 10;
  localparam int PIPE_LATENCY = 5;
  localparam int HOLD_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int IDLE_PERCENT = 19;
  localparam int MAX_PRINTS = 40;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_PIXELS = 95;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [8:0]         low;
    logic [7:0]         high;
    logic [23:0]        tint;
    logic [1:0]         mode;
    logic               invert;
    logic [15:0]        const_alpha;
    logic signed [15:0] lin;
    logic signed [15:0] root;
  } tint_cfg_t;

  typedef struct packed {
    logic [1:0] cut;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = gtr_pkg::REG_LOW_THRESHOLD;
  logic [23:0] cfg_data = 24'd0;

  tint_cfg_t cur_cfg;
  rgba_t     pending_pixels[$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  int        stall_left = 0;
  bit        stall_request = 1'b0;
  bit        tx_idle_on = 1'b1;
  bit        rx_idle_on = 1'b1;

  gray_to_tinted_rgba uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic tint_cfg_t reset_cfg();
    tint_cfg_t c;
    c.low = 9'd0;
    c.high = 8'd255;
    c.tint = 24'hFFFFFF;
    c.mode = gtr_pkg::MODE_CONST;
    c.invert = 1'b0;
    c.const_alpha = 16'd255;
    c.lin = 16'sd256;
    c.root = 16'sd4096;
    return c;
  endfunction

  function automatic int unsigned floor_sqrt(input int unsigned n);
    int unsigned acc;
    int unsigned trial;
    int b;
    acc = 0;
    for (b = 11; b >= 0; b--) begin
      trial = acc | (32'd1 << b);
      if (trial * trial <= n) acc = trial;
    end
    return acc;
  endfunction

  function automatic rgba_t tint_pixel(input logic [7:0] gray, input tint_cfg_t c);
    rgba_t px;
    int unsigned g;
    int unsigned ga;
    longint level;
    g = gray;
    px = '0;
    if (g < c.low) begin
      px.cut = gtr_pkg::CUT_LOW;
      return px;
    end
    if (g > c.high) begin
      px.cut = gtr_pkg::CUT_HIGH;
      return px;
    end
    px.cut = gtr_pkg::CUT_NONE;
    px.red = 8'((g * c.tint[23:16]) / 255);
    px.green = 8'((g * c.tint[15:8]) / 255);
    px.blue = 8'((g * c.tint[7:0]) / 255);
    ga = c.invert ? 255 - g : g;
    case (c.mode)
      gtr_pkg::MODE_LINEAR: level = (longint'(ga) * longint'(c.lin)) / 256;
      gtr_pkg::MODE_ROOT:
        level = (longint'(floor_sqrt(ga << 16)) * longint'(c.root)) / 65536;
      default: level = longint'(c.const_alpha);
    endcase
    if (level < 0) px.alpha = 8'd0;
    else if (level > 255) px.alpha = 8'd255;
    else px.alpha = 8'(level);
    return px;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  task automatic check_beat();
    rgba_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch("output beat with no pixel pending", 0, m_axis_tdata);
      return;
    end
    want = pending_pixels.pop_front();
    if (m_axis_tdata[7:0] !== want.red) report_mismatch("red", want.red, m_axis_tdata[7:0]);
    if (m_axis_tdata[15:8] !== want.green)
      report_mismatch("green", want.green, m_axis_tdata[15:8]);
    if (m_axis_tdata[23:16] !== want.blue)
      report_mismatch("blue", want.blue, m_axis_tdata[23:16]);
    if (m_axis_tdata[31:24] !== want.alpha)
      report_mismatch("alpha", want.alpha, m_axis_tdata[31:24]);
    if (m_axis_tuser !== want.cut) report_mismatch("cut reason", want.cut, m_axis_tuser);
  endtask

  // The output side checks each beat and picks its ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_beat();
    if (stall_request) begin
      stall_left = HOLD_CYCLES;
      stall_request = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rx_idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_pixel(input logic [7:0] gray);
    while (tx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= gray;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_pixels.insert(pending_pixels.size(), tint_pixel(gray, cur_cfg));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [23:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic apply_config(input tint_cfg_t c);
    wait_drained();
    write_reg(gtr_pkg::REG_LOW_THRESHOLD, 24'(c.low));
    write_reg(gtr_pkg::REG_HIGH_THRESHOLD, 24'(c.high));
    write_reg(gtr_pkg::REG_TINT_COLOR, c.tint);
    write_reg(gtr_pkg::REG_ALPHA_MODE, 24'(c.mode));
    write_reg(gtr_pkg::REG_INVERT_ALPHA, 24'(c.invert));
    write_reg(gtr_pkg::REG_CONSTANT_ALPHA, 24'(c.const_alpha));
    write_reg(gtr_pkg::REG_LINEAR_COEF, {8'd0, c.lin});
    write_reg(gtr_pkg::REG_ROOT_COEF, {8'd0, c.root});
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic test_defaults();
    apply_config(reset_cfg());
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd128);
    send_pixel(8'd1);
  endtask

  // When both cuts hold, the low cut must win.
  task automatic test_thresholds();
    tint_cfg_t c;
    c = reset_cfg();
    c.low = 9'd256;
    apply_config(c);
    send_pixel(8'd0);
    send_pixel(8'd255);
    c.low = 9'd100;
    c.high = 8'd50;
    apply_config(c);
    send_pixel(8'd75);
    send_pixel(8'd200);
    send_pixel(8'd30);
    c.low = 9'd0;
    c.high = 8'd0;
    apply_config(c);
    send_pixel(8'd0);
    send_pixel(8'd1);
  endtask

  task automatic test_alpha_modes();
    tint_cfg_t c;
    c = reset_cfg();
    c.const_alpha = 16'hFFFF;
    c.tint = 24'h123456;
    apply_config(c);
    send_pixel(8'd200);
    c.mode = MODE_SPARE;
    c.const_alpha = 16'd0;
    c.invert = 1'b1;
    apply_config(c);
    send_pixel(8'd100);
    c.mode = gtr_pkg::MODE_LINEAR;
    c.invert = 1'b0;
    c.lin = 16'h7FFF;
    c.tint = 24'd0;
    apply_config(c);
    send_pixel(8'd255);
    send_pixel(8'd0);
    c.lin = 16'h8000;
    apply_config(c);
    send_pixel(8'd255);
    c.lin = 16'sd256;
    c.invert = 1'b1;
    apply_config(c);
    send_pixel(8'd0);
    c = reset_cfg();
    c.mode = gtr_pkg::MODE_ROOT;
    apply_config(c);
    send_pixel(8'd255);
    c.root = 16'h7FFF;
    apply_config(c);
    send_pixel(8'd1);
    c.root = 16'h8000;
    apply_config(c);
    send_pixel(8'd255);
    c.root = 16'sd4096;
    c.invert = 1'b1;
    apply_config(c);
    send_pixel(8'd255);
  endtask

  // The output side holds off long enough for the pipeline to fill and stall its input.
  task automatic test_backpressure();
    tint_cfg_t c;
    int n;
    c = reset_cfg();
    c.mode = gtr_pkg::MODE_ROOT;
    c.tint = 24'hA0C0E0;
    apply_config(c);
    stall_request = 1'b1;
    for (n = 0; n < 40; n++) send_pixel(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  task automatic test_random();
    tint_cfg_t c;
    int phase;
    int n;
    logic [7:0] gray;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      c = reset_cfg();
      if (phase == 0) begin
        c.mode = gtr_pkg::MODE_LINEAR;
        c.const_alpha = 16'hFFFF;
        c.lin = 16'h7FFF;
        c.root = 16'h7FFF;
      end else if (phase == PHASE_COUNT - 1) begin
        c.tint = 24'd0;
        c.mode = gtr_pkg::MODE_ROOT;
        c.invert = 1'b1;
        c.const_alpha = 16'd0;
        c.lin = 16'h8000;
        c.root = 16'h8000;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            c.low = 9'd0;
            c.high = 8'd255;
          end
          1: begin
            c.low = 9'($urandom_range(0, 256));
            c.high = 8'($urandom_range(0, 255));
          end
          default: begin
            c.low = 9'($urandom_range(0, 80));
            c.high = 8'($urandom_range(170, 255));
          end
        endcase
        c.tint = 24'($urandom);
        c.mode = 2'($urandom_range(0, 3));
        c.invert = 1'($urandom_range(0, 1));
        c.const_alpha = $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : 16'($urandom);
        c.lin = $urandom_range(0, 1) ? 16'($urandom_range(0, 1024)) : 16'($urandom);
        c.root = $urandom_range(0, 1) ? 16'($urandom_range(0, 8192)) : 16'($urandom);
      end
      apply_config(c);
      tx_idle_on = (phase != 3);
      rx_idle_on = (phase != 3);
      for (n = 0; n < PHASE_PIXELS; n++) begin
        gray = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0: gray = 8'(cur_cfg.low - 9'd1);
            1: gray = 8'(cur_cfg.low);
            2: gray = cur_cfg.high;
            default: gray = cur_cfg.high + 8'd1;
          endcase
        end
        send_pixel(gray);
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    cur_cfg = reset_cfg();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_thresholds();
    test_alpha_modes();
    test_backpressure();
    test_random();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
